// ===== hdl/cpf_pkg.sv =====
`timescale 1ns / 1ps

package cpf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 2'd2;

  localparam logic [16:0] MAX_FRAME_RST  = 17'd65544;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [3:0] {
    STEP_HEAD,
    STEP_SYNC1,
    STEP_TYPE,
    STEP_SEQ_LO,
    STEP_SEQ_HI,
    STEP_LEN_LO,
    STEP_LEN_HI,
    STEP_CRC_LO,
    STEP_CRC_HI
  } cpf_step_e;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [16:0] max_frame_bytes;
  } cpf_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  frame_type;
    logic [15:0] sequence_req;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } cpf_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       too_large;
    logic       last_of_run;
  } cpf_res_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/cpf_in_if.sv =====
`timescale 1ns / 1ps

interface cpf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  frame_type;
  logic [15:0] sequence_req;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (
    output valid, kind, frame_type, sequence_req, payload_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, frame_type, sequence_req, payload_length, payload_byte,
    output ready
  );
endinterface

// ===== hdl/cpf_out_if.sv =====
`timescale 1ns / 1ps

interface cpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       too_large;
  logic       last_of_run;

  modport source (
    output valid, out_byte, frame_end, too_large, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_byte, frame_end, too_large, last_of_run,
    output ready
  );
endinterface

// ===== hdl/cpf_cfg_regs.sv =====
`timescale 1ns / 1ps

module cpf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output cpf_pkg::cpf_cfg_t              cfg_o
);

  cpf_pkg::cpf_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cpf_pkg::CFG_MAGIC_FIRST:     cfg_d.magic_first     = cfg_wdata_i[7:0];
        cpf_pkg::CFG_MAGIC_SECOND:    cfg_d.magic_second    = cfg_wdata_i[7:0];
        cpf_pkg::CFG_MAX_FRAME_BYTES: cfg_d.max_frame_bytes = cfg_wdata_i[16:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_first     <= 8'h00;
      cfg_q.magic_second    <= 8'h00;
      cfg_q.max_frame_bytes <= cpf_pkg::MAX_FRAME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/cpf_seq.sv =====
`timescale 1ns / 1ps

module cpf_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  cpf_in_if.sink            in_i,
  input  cpf_pkg::cpf_cfg_t cfg_i,
  output logic              res_vld_o,
  output cpf_pkg::cpf_res_t res_o,
  input  logic              res_ready_i
);

  cpf_pkg::cpf_item_t item_q;
  logic               item_vld_q;
  cpf_pkg::cpf_step_e step_q, step_d;

  logic [15:0] crc_q, crc_d;
  logic [15:0] rem_q, rem_d;
  logic        open_q, open_d;
  logic        disc_q, disc_d;

  logic        step_go;
  logic        item_done;
  logic        in_acc;
  logic [15:0] rem_dec;
  logic        oversize;

  assign rem_dec  = rem_q - 16'd1;
  assign oversize = ({1'b0, item_q.payload_length} + cpf_pkg::FRAME_OVERHEAD)
                    > cfg_i.max_frame_bytes;

  // result and state update for the current step
  always_comb begin
    res_vld_o = 1'b0;
    res_o     = '0;
    crc_d     = crc_q;
    rem_d     = rem_q;
    open_d    = open_q;
    disc_d    = disc_q;
    if (item_vld_q) begin
      case (step_q)
        cpf_pkg::STEP_HEAD: begin
          if (item_q.kind == cpf_pkg::KIND_HEADER) begin
            // a new header abandons any open frame
            res_vld_o = 1'b1;
            open_d    = 1'b0;
            disc_d    = 1'b0;
            crc_d     = cpf_pkg::CRC_INIT;
            rem_d     = 16'd0;
            if (oversize) begin
              res_o.too_large   = 1'b1;
              res_o.last_of_run = 1'b1;
              rem_d             = item_q.payload_length;
              disc_d            = item_q.payload_length != 16'd0;
            end else begin
              res_o.out_byte = cfg_i.magic_first;
            end
          end else if (open_q) begin
            res_vld_o         = 1'b1;
            res_o.out_byte    = item_q.payload_byte;
            res_o.last_of_run = rem_dec != 16'd0;
            crc_d             = cpf_pkg::crc_byte(crc_q, item_q.payload_byte);
            rem_d             = rem_dec;
          end else if (disc_q) begin
            rem_d  = rem_dec;
            disc_d = rem_dec != 16'd0;
          end
        end
        cpf_pkg::STEP_SYNC1: begin
          res_vld_o      = 1'b1;
          res_o.out_byte = cfg_i.magic_second;
        end
        cpf_pkg::STEP_TYPE: begin
          res_vld_o      = 1'b1;
          res_o.out_byte = item_q.frame_type;
          crc_d          = cpf_pkg::crc_byte(crc_q, item_q.frame_type);
        end
        cpf_pkg::STEP_SEQ_LO: begin
          res_vld_o      = 1'b1;
          res_o.out_byte = item_q.sequence_req[7:0];
          crc_d          = cpf_pkg::crc_byte(crc_q, item_q.sequence_req[7:0]);
        end
        cpf_pkg::STEP_SEQ_HI: begin
          res_vld_o      = 1'b1;
          res_o.out_byte = item_q.sequence_req[15:8];
          crc_d          = cpf_pkg::crc_byte(crc_q, item_q.sequence_req[15:8]);
        end
        cpf_pkg::STEP_LEN_LO: begin
          res_vld_o      = 1'b1;
          res_o.out_byte = item_q.payload_length[7:0];
          crc_d          = cpf_pkg::crc_byte(crc_q, item_q.payload_length[7:0]);
        end
        cpf_pkg::STEP_LEN_HI: begin
          res_vld_o      = 1'b1;
          res_o.out_byte = item_q.payload_length[15:8];
          crc_d          = cpf_pkg::crc_byte(crc_q, item_q.payload_length[15:8]);
          if (item_q.payload_length != 16'd0) begin
            res_o.last_of_run = 1'b1;
            open_d            = 1'b1;
            rem_d             = item_q.payload_length;
          end
        end
        cpf_pkg::STEP_CRC_LO: begin
          res_vld_o      = 1'b1;
          res_o.out_byte = crc_q[7:0];
        end
        cpf_pkg::STEP_CRC_HI: begin
          res_vld_o         = 1'b1;
          res_o.out_byte    = crc_q[15:8];
          res_o.frame_end   = 1'b1;
          res_o.last_of_run = 1'b1;
          open_d            = 1'b0;
          rem_d             = 16'd0;
        end
        default: ;
      endcase
    end
  end

  // steps without a result need no room downstream
  assign step_go   = item_vld_q && (!res_vld_o || res_ready_i);
  assign item_done = step_go && (!res_vld_o || res_o.last_of_run);
  assign in_i.ready = !item_vld_q || item_done;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    step_d = step_q;
    if (step_go) begin
      if (item_done) begin
        step_d = cpf_pkg::STEP_HEAD;
      end else begin
        case (step_q)
          cpf_pkg::STEP_HEAD: begin
            if (item_q.kind == cpf_pkg::KIND_HEADER) begin
              step_d = cpf_pkg::STEP_SYNC1;
            end else begin
              step_d = cpf_pkg::STEP_CRC_LO;
            end
          end
          cpf_pkg::STEP_SYNC1:  step_d = cpf_pkg::STEP_TYPE;
          cpf_pkg::STEP_TYPE:   step_d = cpf_pkg::STEP_SEQ_LO;
          cpf_pkg::STEP_SEQ_LO: step_d = cpf_pkg::STEP_SEQ_HI;
          cpf_pkg::STEP_SEQ_HI: step_d = cpf_pkg::STEP_LEN_LO;
          cpf_pkg::STEP_LEN_LO: step_d = cpf_pkg::STEP_LEN_HI;
          cpf_pkg::STEP_LEN_HI: step_d = cpf_pkg::STEP_CRC_LO;
          cpf_pkg::STEP_CRC_LO: step_d = cpf_pkg::STEP_CRC_HI;
          default:              step_d = cpf_pkg::STEP_HEAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      step_q     <= cpf_pkg::STEP_HEAD;
      crc_q      <= cpf_pkg::CRC_INIT;
      rem_q      <= 16'd0;
      open_q     <= 1'b0;
      disc_q     <= 1'b0;
    end else begin
      step_q <= step_d;
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
      end
      if (step_go) begin
        crc_q  <= crc_d;
        rem_q  <= rem_d;
        open_q <= open_d;
        disc_q <= disc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.kind           <= in_i.kind;
      item_q.frame_type     <= in_i.frame_type;
      item_q.sequence_req   <= in_i.sequence_req;
      item_q.payload_length <= in_i.payload_length;
      item_q.payload_byte   <= in_i.payload_byte;
    end
  end

  a_open_disc_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(open_q && disc_q))
    else $error("frame open and discarding at once");

  a_idle_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_vld_q |-> step_q == cpf_pkg::STEP_HEAD)
    else $error("step counter away from head with no item");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && (res_o.frame_end || res_o.too_large) |-> res_o.last_of_run)
    else $error("frame end or error result not last of its run");

  a_crc_tail_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && step_q == cpf_pkg::STEP_CRC_HI |=> !open_q && rem_q == 16'd0)
    else $error("frame still open after its CRC");

endmodule

// ===== hdl/cpf_out_reg.sv =====
`timescale 1ns / 1ps

module cpf_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_vld_i,
  input  cpf_pkg::cpf_res_t res_i,
  output logic              res_ready_o,
  cpf_out_if.source         out_o
);

  logic              vld_q;
  cpf_pkg::cpf_res_t res_q;
  logic              load;

  // take a new item while the held one leaves
  assign res_ready_o = !vld_q || out_o.ready;
  assign load        = res_vld_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (res_ready_o) begin
      vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = vld_q;
  assign out_o.out_byte    = res_q.out_byte;
  assign out_o.frame_end   = res_q.frame_end;
  assign out_o.too_large   = res_q.too_large;
  assign out_o.last_of_run = res_q.last_of_run;

endmodule

// ===== hdl/crc16_packet_framer_core.sv =====
`timescale 1ns / 1ps

// Packet framer with CRC-16/CCITT-FALSE. The output port moves one byte per
// cycle while the receiver is ready, and the step sequencer produces one result
// per cycle with a byte-wide CRC update unless the output register is full; an
// item stays in the sequencer until it has yielded all of its results: a payload
// byte of an open frame yields 1 byte (3 when it is the last one and the CRC
// follows), a header 7 bytes (9 with zero payload length), a rejected header
// 1 result. Payload items that are dropped or fall outside a frame yield
// nothing. The first result of an item is formed from the item register and
// registered in the output register before it is offered at the output; the
// output register lets the next item enter while a result waits to be taken.

module crc16_packet_framer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cpf_in_if.sink                         in_i,
  cpf_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [cpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  cpf_pkg::cpf_cfg_t cfg;
  cpf_pkg::cpf_res_t res;
  logic              res_vld;
  logic              res_ready;

  cpf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cpf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .res_vld_o   (res_vld),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  cpf_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule
